// ===== sv/hawa_pkg.sv =====
// Package: types, constants and register indexes for the hang/attack-wait AGC.
package hawa_pkg;
  localparam int SAMPLE_BITS = 16;
  localparam int SB = SAMPLE_BITS;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FIFO_DEPTH = 2;

  localparam logic [31:0] GAIN_RESET = 32'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HANG        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_WAIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_GAIN   = 3'd7;

  typedef struct packed {
    logic signed [SB-1:0] sample_in;
    logic                 block_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SB-1:0] sample_out;
    logic [31:0]          gain_now;
  } out_item_t;

  // front-end classified item
  typedef struct packed {
    logic          start;
    logic          neg;
    logic [SB-1:0] mag;
  } work_t;

  typedef struct packed {
    logic [14:0] reference_level;
    logic [15:0] attack_coef;
    logic [15:0] decay_coef;
    logic [31:0] gain_ceiling;
    logic [14:0] hang_samples;
    logic [14:0] attack_wait_samples;
    logic [15:0] filter_alpha;
    logic [31:0] initial_gain;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_DECIDE, ST_MUL, ST_UPD, ST_FILT, ST_CLAMP, ST_SCALE, ST_OUT
  } back_state_e;
endpackage

// ===== sv/hawa_front.sv =====
// Front end: accepts items, classifies start and sign, passes magnitudes to the work queue.
module hawa_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  hawa_pkg::in_item_t  in_item_i,
  output logic                wr_valid_o,
  output hawa_pkg::work_t     wr_item_o,
  input  logic                wr_ready_i
);
  import hawa_pkg::*;

  logic started_q, started_d;
  logic acc;
  logic [SB-1:0] s;

  assign full = !wr_ready_i;
  assign acc  = push && wr_ready_i;
  assign wr_valid_o = acc;
  assign s = in_item_i.sample_in;

  always_comb begin
    wr_item_o.start = in_item_i.block_start || !started_q;
    wr_item_o.neg   = s[SB-1];
    wr_item_o.mag   = s[SB-1] ? (~s + 1'b1) : s;
    started_d = started_q | acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
    end else begin
      started_q <= started_d;
    end
  end
endmodule

// ===== sv/hawa_fifo.sv =====
// Small queue between front end and back end, plus the result queue.
module hawa_fifo #(
  parameter int W = 18
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_i,
  input  logic [W-1:0] wdata_i,
  output logic         ready_o,
  output logic         valid_o,
  output logic [W-1:0] rdata_o,
  input  logic         rd_i
);
  import hawa_pkg::*;

  logic [W-1:0] mem_q [FIFO_DEPTH];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;
  logic         do_wr, do_rd;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rp_q];
  assign do_wr = wr_i && ready_o;
  assign do_rd = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_wr) wp_q <= ~wp_q;
      if (do_rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end
endmodule

// ===== sv/hawa_back.sv =====
// Back end: serial divider, gain update, filter and output scaling.
module hawa_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hawa_pkg::cfg_t      cfg_i,
  input  logic                rd_valid_i,
  input  hawa_pkg::work_t     rd_item_i,
  output logic                rd_o,
  output logic                res_valid_o,
  output hawa_pkg::out_item_t res_o,
  input  logic                res_ready_i
);
  import hawa_pkg::*;

  back_state_e st_q, st_d;
  work_t       it_q;
  logic [31:0] gain_q;
  logic [SB-1:0] peak_q;
  logic [14:0] hang_q, wait_q;
  logic [31:0] g_q;
  logic [5:0]  cnt_q;
  logic [47:0] num_q;
  logic [32:0] rem_q;
  logic [31:0] div_q;
  logic        dodiv_q, upd_neg_q, do_upd_q;
  logic [31:0] err_q;
  logic [47:0] prod_q;
  logic [32:0] gsum_q;

  logic [SB-1:0] ref_s;
  logic [31:0]   ratio_sat;
  logic [32:0]   rem_sh;
  logic [31:0]   divisor;
  logic [47:0]   mulr;
  logic [15:0]   rate;
  logic [SB+31:0] smul;
  logic [SB+15:0] smag;
  logic [SB:0]    smag_c;
  logic [SB-1:0]  sout;

  assign ref_s = SB'(({9'd0, cfg_i.reference_level} << 8) >> (24 - SB));
  assign divisor = it_q.start ? gain_q : {{(32-SB){1'b0}}, it_q.mag};
  assign rem_sh = {rem_q[31:0], num_q[47]};
  assign ratio_sat = (div_q[31:SB] != '0 && it_q.start) ? '1 : div_q;
  assign rate = upd_neg_q ? cfg_i.attack_coef : cfg_i.decay_coef;
  assign mulr = 48'(err_q) * 48'(rate);
  assign smul = (SB+32)'(it_q.mag) * (SB+32)'(g_q);
  assign smag = smul[SB+31:16];
  always_comb begin
    smag_c = (smag > (SB+16)'(1) << SB) ? (SB+1)'(1) << SB : smag[SB:0];
    if (it_q.neg) begin
      sout = (smag_c > ((SB+1)'(1) << (SB-1))) ? {1'b1, {(SB-1){1'b0}}}
                                               : SB'(~smag_c + 1'b1);
    end else begin
      sout = (smag_c > ((SB+1)'(1) << (SB-1)) - 1'b1) ? {1'b0, {(SB-1){1'b1}}}
                                                       : smag_c[SB-1:0];
    end
  end

  assign rd_o = (st_q == ST_IDLE) && rd_valid_i;
  assign res_valid_o = (st_q == ST_OUT);
  assign res_o.sample_out = sout;
  assign res_o.gain_now = g_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:   if (rd_valid_i) st_d = ST_DIV;
      ST_DIV:    if (!dodiv_q || cnt_q == 6'd48) st_d = it_q.start ? ST_SCALE : ST_DECIDE;
      ST_DECIDE: st_d = ST_MUL;
      ST_MUL:    st_d = ST_UPD;
      ST_UPD:    st_d = ST_FILT;
      ST_FILT:   st_d = ST_CLAMP;
      ST_CLAMP:  st_d = ST_SCALE;
      ST_SCALE:  st_d = ST_OUT;
      ST_OUT:    if (res_ready_i) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      gain_q <= GAIN_RESET;
      peak_q <= '0;
      hang_q <= '0;
      wait_q <= '0;
    end else begin
      st_q <= st_d;
      case (st_q)
        ST_IDLE: begin
          if (rd_valid_i) begin
            it_q <= rd_item_i;
            cnt_q <= '0;
            num_q <= 48'({ref_s, 16'd0});
            rem_q <= '0;
            div_q <= '0;
            dodiv_q <= rd_item_i.start ? (gain_q != '0) : (rd_item_i.mag != '0);
          end
        end
        ST_DIV: begin
          if (dodiv_q && cnt_q != 6'd48) begin
            cnt_q <= cnt_q + 1'b1;
            num_q <= num_q << 1;
            if (rem_sh >= {1'b0, divisor}) begin
              rem_q <= rem_sh - {1'b0, divisor};
              div_q <= (div_q[31] ? 32'hFFFF_FFFF : {div_q[30:0], 1'b1});
            end else begin
              rem_q <= rem_sh;
              div_q <= (div_q[31] ? 32'hFFFF_FFFF : {div_q[30:0], 1'b0});
            end
          end else begin
            g_q <= gain_q;
            if (it_q.start) begin
              peak_q <= dodiv_q ? ratio_sat[SB-1:0] : '1;
              hang_q <= '0;
              wait_q <= '0;
            end
          end
        end
        ST_DECIDE: begin
          do_upd_q <= 1'b0;
          if (dodiv_q) begin
            if (div_q < gain_q) begin
              upd_neg_q <= 1'b1;
              err_q <= gain_q - div_q;
              if (peak_q < it_q.mag || wait_q != '0) begin
                if (peak_q < it_q.mag) peak_q <= it_q.mag;
                if (peak_q < it_q.mag) begin
                  if (cfg_i.attack_wait_samples != '0)
                    wait_q <= cfg_i.attack_wait_samples - 1'b1;
                  else begin
                    do_upd_q <= 1'b1;
                    hang_q <= cfg_i.hang_samples;
                  end
                end else wait_q <= wait_q - 1'b1;
              end else begin
                do_upd_q <= 1'b1;
                hang_q <= cfg_i.hang_samples;
              end
            end else begin
              upd_neg_q <= 1'b0;
              err_q <= div_q - gain_q;
              if (hang_q != '0) hang_q <= hang_q - 1'b1;
              else do_upd_q <= 1'b1;
            end
          end
        end
        ST_MUL: prod_q <= do_upd_q ? mulr : '0;
        ST_UPD: begin
          gsum_q <= upd_neg_q ? ({1'b0, g_q} - {1'b0, prod_q[47:16]})
                              : ({1'b0, g_q} + {1'b0, prod_q[47:16]});
          prod_q <= 48'(gain_q) * 48'(17'h10000 - {1'b0, cfg_i.filter_alpha});
        end
        ST_FILT: begin
          gsum_q <= ((gsum_q > {1'b0, cfg_i.gain_ceiling}) ? {1'b0, cfg_i.gain_ceiling}
                                                           : gsum_q)
                    + {1'b0, prod_q[47:16]};
        end
        ST_CLAMP: begin
          g_q <= gsum_q[32] ? 32'hFFFF_FFFF : gsum_q[31:0];
          gain_q <= gsum_q[32] ? 32'hFFFF_FFFF : gsum_q[31:0];
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== sv/hang_attack_wait_agc.sv =====
// Top level: config registers, front end, work queue, back end, result queue.
//  channel | handshake     | payload
//  input   | push / full   | in_item_i  (sample_in, block_start)
//  result  | empty / pop   | out_item_o (sample_out, gain_now)
//  config  | cfg_we_i      | cfg_idx_i, cfg_data_i
// A nonzero sample goes through the 48-step restoring divider and the gain update;
// a start item divides but skips the update, and a zero sample skips the division.
// Reset loads the gain with its reset value; writes of initial_gain never reach it.
// Input and result sides stall independently through two-entry queues; the back
// end holds a finished result until the result queue has room.
module hang_attack_wait_agc (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  hawa_pkg::in_item_t                in_item_i,
  output logic                              empty,
  input  logic                              pop,
  output hawa_pkg::out_item_t               out_item_o,
  input  logic                              cfg_we_i,
  input  logic [hawa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hawa_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import hawa_pkg::*;

  cfg_t cfg_q;
  logic wv, wr_rdy, qv, qrd, rv, rrdy, ovalid;
  work_t wi, qi;
  out_item_t ri;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{15'd16384, 16'd655, 16'd66, 32'hFFFF_FFFF, 15'd192, 15'd0,
                 16'd847, 32'd65536};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_REFERENCE:   cfg_q.reference_level <= cfg_data_i[14:0];
        REG_ATTACK:      cfg_q.attack_coef <= cfg_data_i[15:0];
        REG_DECAY:       cfg_q.decay_coef <= cfg_data_i[15:0];
        REG_MAX_GAIN:    cfg_q.gain_ceiling <= cfg_data_i;
        REG_HANG:        cfg_q.hang_samples <= cfg_data_i[14:0];
        REG_ATTACK_WAIT: cfg_q.attack_wait_samples <= cfg_data_i[14:0];
        REG_ALPHA:       cfg_q.filter_alpha <= cfg_data_i[15:0];
        REG_INIT_GAIN:   cfg_q.initial_gain <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hawa_front u_front (.clk_i, .rst_ni, .push, .full, .in_item_i,
    .wr_valid_o(wv), .wr_item_o(wi), .wr_ready_i(wr_rdy));

  hawa_fifo #(.W($bits(work_t))) u_wq (.clk_i, .rst_ni, .wr_i(wv), .wdata_i(wi),
    .ready_o(wr_rdy), .valid_o(qv), .rdata_o(qi), .rd_i(qrd));

  hawa_back u_back (.clk_i, .rst_ni, .cfg_i(cfg_q), .rd_valid_i(qv), .rd_item_i(qi),
    .rd_o(qrd), .res_valid_o(rv), .res_o(ri), .res_ready_i(rrdy));

  hawa_fifo #(.W($bits(out_item_t))) u_rq (.clk_i, .rst_ni, .wr_i(rv), .wdata_i(ri),
    .ready_o(rrdy), .valid_o(ovalid), .rdata_o(out_item_o), .rd_i(pop));

  assign empty = !ovalid;
endmodule

// ===== sv/hawa_checker.sv =====
// Port-level checker for the AGC and its bind.
module hawa_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop
);
  a_no_out_after_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty)
    else $error("result present right after reset");
  a_not_full_reset: assert property (@(posedge clk_i) !rst_ni |=> !full || !rst_ni)
    else $error("full during reset");
  a_pop_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped without transfer");
endmodule

bind hang_attack_wait_agc hawa_checker u_chk (.clk_i, .rst_ni, .push, .full, .empty, .pop);

// ===== tb/tb_hang_attack_wait_agc.sv =====
// Testbench for the hang/attack-wait AGC: directed, configuration, back-pressure and random tests.
`timescale 1ns / 1ps

module tb_hang_attack_wait_agc;
  import hawa_pkg::*;

  localparam int HALF = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_item_t in_item_i = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_REFERENCE;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  hang_attack_wait_agc uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full), .in_item_i(in_item_i),
    .empty(empty), .pop(pop), .out_item_o(out_item_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #HALF clk_i = ~clk_i;

  cfg_t agc_cfg;
  logic [63:0] gain_acc, peak_mag, hang_ctr, wait_ctr;
  bit primed;
  out_item_t gain_out_q[$];
  int unsigned fail_cnt = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  int unsigned holdoff_cycles = 0;

  function automatic logic [SB-1:0] scale_sample(longint x, logic [63:0] g);
    logic [63:0] mag;
    longint q;
    mag = (64'(x < 0 ? -x : x) * g) >> 16;
    if (mag > (64'd1 << SB)) mag = 64'd1 << SB;
    q = x < 0 ? -longint'(mag) : longint'(mag);
    if (q > (longint'(1) << (SB - 1)) - 1) q = (longint'(1) << (SB - 1)) - 1;
    if (q < -(longint'(1) << (SB - 1))) q = -(longint'(1) << (SB - 1));
    return q[SB-1:0];
  endfunction

  function automatic out_item_t agc_predict(in_item_t it);
    longint x;
    logic [63:0] ax, ref_s, g, ratio, pk;
    out_item_t r;
    x = longint'(it.sample_in);
    ax = 64'(x < 0 ? -x : x);
    ref_s = (64'(agc_cfg.reference_level) << 8) >> (24 - SB);
    if (it.block_start || !primed) begin
      pk = (64'd1 << SB) - 1;
      if (gain_acc != 0) begin
        pk = (ref_s << 16) / gain_acc;
        if (pk > (64'd1 << SB) - 1) pk = (64'd1 << SB) - 1;
      end
      peak_mag = pk;
      hang_ctr = 0;
      wait_ctr = 0;
      primed = 1'b1;
      r.sample_out = scale_sample(x, gain_acc);
      r.gain_now = gain_acc[31:0];
      return r;
    end
    g = gain_acc;
    if (ax != 0) begin
      ratio = (ref_s << 16) / ax;
      if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
      if (ratio < g) begin
        if (peak_mag < ax) begin
          wait_ctr = agc_cfg.attack_wait_samples;
          peak_mag = ax;
        end
        if (wait_ctr > 0) begin
          wait_ctr--;
        end else begin
          g -= ((g - ratio) * agc_cfg.attack_coef) >> 16;
          hang_ctr = agc_cfg.hang_samples;
        end
      end else begin
        if (hang_ctr > 0) hang_ctr--;
        else g += ((ratio - g) * agc_cfg.decay_coef) >> 16;
      end
    end
    if (g > agc_cfg.gain_ceiling) g = agc_cfg.gain_ceiling;
    g += (gain_acc * (64'd65536 - agc_cfg.filter_alpha)) >> 16;
    if (g > 64'hFFFF_FFFF) g = 64'hFFFF_FFFF;
    gain_acc = g;
    r.sample_out = scale_sample(x, g);
    r.gain_now = g[31:0];
    return r;
  endfunction

  task automatic send_sample(logic signed [SB-1:0] s, logic bs);
    int unsigned gap;
    in_item_t it;
    gap = send_gaps ? $urandom_range(0, 14) : 0;
    it.sample_in = s;
    it.block_start = bs;
    repeat (gap) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    gain_out_q.push_back(agc_predict(it));
  endtask

  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    wait (gain_out_q.size() == 0);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_REFERENCE:   agc_cfg.reference_level = val[14:0];
      REG_ATTACK:      agc_cfg.attack_coef = val[15:0];
      REG_DECAY:       agc_cfg.decay_coef = val[15:0];
      REG_MAX_GAIN:    agc_cfg.gain_ceiling = val;
      REG_HANG:        agc_cfg.hang_samples = val[14:0];
      REG_ATTACK_WAIT: agc_cfg.attack_wait_samples = val[14:0];
      REG_ALPHA:       agc_cfg.filter_alpha = val[15:0];
      default:         agc_cfg.initial_gain = val;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [SB-1:0] rand_sample();
    logic signed [SB-1:0] s;
    s = SB'($urandom);
    if ($urandom_range(0, 15) == 0) return '0;
    return s >>> $urandom_range(0, 15);
  endfunction

  task automatic random_blocks(int unsigned n);
    repeat (n) send_sample(rand_sample(), $urandom_range(0, 63) == 0);
  endtask

  task automatic test_directed();
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd20000, 1'b1);
    send_sample(16'sd30000, 1'b0);
    send_sample(16'sd31000, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shAAAA, 1'b0);
    settle();
  endtask

  task automatic test_config_sweep();
    write_reg(REG_INIT_GAIN, 32'h0002_0000);
    write_reg(REG_HANG, 32'd0);
    write_reg(REG_ATTACK_WAIT, 32'd3);
    write_reg(REG_ATTACK, 32'hFFFF);
    write_reg(REG_DECAY, 32'hFFFF);
    write_reg(REG_ALPHA, 32'hFFFF);
    write_reg(REG_REFERENCE, 32'h7FFF);
    send_sample(16'sd1000, 1'b1);
    random_blocks(60);
    settle();
    write_reg(REG_MAX_GAIN, 32'd0);
    write_reg(REG_ALPHA, 32'd0);
    write_reg(REG_REFERENCE, 32'd0);
    random_blocks(40);
    settle();
    write_reg(REG_MAX_GAIN, 32'h0004_0000);
    write_reg(REG_REFERENCE, 32'h0000_FFFF);
    write_reg(REG_ATTACK_WAIT, 32'h7FFF);
    write_reg(REG_HANG, 32'h7FFF);
    write_reg(REG_ALPHA, 32'd30000);
    random_blocks(60);
    settle();
    write_reg(REG_MAX_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_ATTACK, 32'd0);
    write_reg(REG_DECAY, 32'd0);
    write_reg(REG_HANG, 32'd5);
    write_reg(REG_ATTACK_WAIT, 32'd0);
    random_blocks(40);
    settle();
  endtask

  task automatic test_random();
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_REFERENCE, $urandom_range(0, 32767));
      write_reg(REG_ATTACK, $urandom_range(0, 65535));
      write_reg(REG_DECAY, $urandom_range(0, 65535));
      write_reg(REG_MAX_GAIN, $urandom_range(0, 3) == 0 ? $urandom : $urandom >> 12);
      write_reg(REG_HANG, $urandom_range(0, 20));
      write_reg(REG_ATTACK_WAIT, $urandom_range(0, 6));
      write_reg(REG_ALPHA, $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                 : $urandom_range(60000, 65535));
      send_gaps = p[0];
      recv_gaps = p[1];
      send_sample(rand_sample(), 1'b1);
      random_blocks(200);
      settle();
    end
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    holdoff_cycles = 400;
    send_gaps = 1'b0;
    random_blocks(20);
    send_gaps = 1'b1;
    settle();
  endtask

  initial begin : rx_check
    out_item_t exp_item;
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = recv_gaps ? $urandom_range(0, 14) : 0;
      if (holdoff_cycles != 0) begin
        stall = holdoff_cycles;
        holdoff_cycles = 0;
      end
      repeat (stall) begin
        @(negedge clk_i);
        pop <= 1'b0;
      end
      @(negedge clk_i);
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (gain_out_q.size() == 0) begin
        $display("%0t unexpected transfer: got %p", $time, out_item_o);
        fail_cnt++;
      end else begin
        exp_item = gain_out_q.pop_front();
        if (out_item_o.sample_out !== exp_item.sample_out) begin
          $display("%0t sample_out: expected %0d, actual %0d", $time,
                   exp_item.sample_out, out_item_o.sample_out);
          fail_cnt++;
        end
        if (out_item_o.gain_now !== exp_item.gain_now) begin
          $display("%0t gain_now: expected %h, actual %h", $time,
                   exp_item.gain_now, out_item_o.gain_now);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    agc_cfg = '{reference_level: 15'd16384, attack_coef: 16'd655, decay_coef: 16'd66,
                gain_ceiling: 32'hFFFF_FFFF, hang_samples: 15'd192,
                attack_wait_samples: 15'd0, filter_alpha: 16'd847,
                initial_gain: 32'd65536};
    gain_acc = 64'(agc_cfg.initial_gain);
    peak_mag = 0;
    hang_ctr = 0;
    wait_ctr = 0;
    primed = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    test_backpressure();
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== hang_attack_wait_agc.f =====
sv/hawa_pkg.sv
sv/hawa_front.sv
sv/hawa_fifo.sv
sv/hawa_back.sv
sv/hang_attack_wait_agc.sv
sv/hawa_checker.sv
tb/tb_hang_attack_wait_agc.sv
